>>> design/ole_pkg.sv
// shared types and codes for the ordered list engine
package ole_pkg;

  localparam int unsigned REQ_W  = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD = 4'd0,
    REQ_INS_END  = 4'd1,
    REQ_INS_AT   = 4'd2,
    REQ_DEL_HEAD = 4'd3,
    REQ_DEL_END  = 4'd4,
    REQ_DEL_VAL  = 4'd5,
    REQ_CLEAR    = 4'd6,
    REQ_FIND     = 4'd7,
    REQ_READ     = 4'd8,
    REQ_WRITE    = 4'd9
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         found_position;
    logic signed [WORD_W-1:0] read_value;
    logic [POS_W-1:0]         count;
    logic                     is_empty;
  } out_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;        // open a gap at idx and load the key there
    logic del_pos;    // close the gap at idx
    logic del_match;  // close the gap at the first matching cell
    logic wr;         // overwrite the cell at idx
  } cell_cmd_t;

endpackage

>>> design/ole_cell.sv
// one list slot: holds a word, compares it with the key, shifts with its neighbors
module ole_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  ole_pkg::cell_cmd_t    cmd_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  seen_i,
  output logic                  seen_o,
  output logic                  first_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  live;
  logic                  match;
  logic                  at_idx;
  logic                  above_idx;

  assign live      = CNT_W'(IDX) < count_i;
  assign match     = live && (data_q == key_i);
  assign at_idx    = idx_i == IDX_W'(IDX);
  assign above_idx = IDX_W'(IDX) > idx_i;

  // prefix of matches runs down the chain
  assign seen_o  = seen_i | match;
  assign first_o = match & ~seen_i;
  assign data_o  = data_q;
  assign rd_o    = at_idx ? data_q : '0;

  always_comb begin
    data_d = data_q;
    priority if (cmd_i.ins) begin
      if (above_idx) begin
        data_d = left_data_i;
      end else if (at_idx) begin
        data_d = key_i;
      end
    end else if (cmd_i.del_pos) begin
      if (above_idx || at_idx) begin
        data_d = right_data_i;
      end
    end else if (cmd_i.del_match) begin
      if (seen_o) begin
        data_d = right_data_i;
      end
    end else if (cmd_i.wr) begin
      if (at_idx) begin
        data_d = key_i;
      end
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

>>> design/ordered_list_engine_unit.sv
// top level of the ordered list engine: request control and the row of list cells
//
// The list lives in a row of CAPACITY cells, one word per cell, in list order from
// cell 0; a count register says how many are in use. The request beat is
// registered at the accepting edge; then, once the output register is free, every
// cell compares its word with the key and, for inserts and deletes, takes the word
// of its left or right neighbor, all at once, while the result beat is loaded into
// the output register. in_stall_o is high for the cycle after an accept, and stays
// high while a finished result is still stalled at the output, since the working
// request can only finish into a free output register. Positions are one-based;
// position and count ports are 7 bits wide, so with CAPACITY above 127 the count
// and found position report their low 7 bits. Words are kept at DATA_WIDTH bits:
// the 32-bit value is sign-extended or cut to that width, and a read sign-extends
// or cuts it back to 32 bits. Cell contents need no reset; only entries under
// the count are ever read.
module ordered_list_engine_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ole_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ole_pkg::out_item_t  out_item_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W =
    ((CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W) + 1;

  // control state
  ole_pkg::state_e    state_q, state_d;
  ole_pkg::in_item_t  req_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  ole_pkg::out_item_t out_q;

  logic               in_accept;
  logic               fire;

  // request decode
  logic [DATA_WIDTH-1:0] key;
  logic [CMP_W-1:0]      cnt_x;
  logic [CMP_W-1:0]      pos_x;
  logic [IDX_W-1:0]      idx_pos;
  logic                  full;
  logic                  empty;

  ole_pkg::status_e      status;
  ole_pkg::cell_cmd_t    cmd;
  ole_pkg::cell_cmd_t    cell_cmd;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      cnt_nx;
  logic [CMP_W-1:0]      cnt_nx_x;
  logic                  want_fpos;
  logic                  want_rval;
  logic [CMP_W-1:0]      fpos_x;
  ole_pkg::out_item_t    res;

  // cell row
  logic [DATA_WIDTH-1:0] data_w [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_w   [CAPACITY];
  logic [CAPACITY:0]     seen_w;
  logic [CAPACITY-1:0]   first_w;
  logic                  found;
  logic [CNT_W-1:0]      fpos_enc;
  logic [DATA_WIDTH-1:0] rd_or;
  logic [ole_pkg::WORD_W-1:0] rd_ext;

  // handshake: one request at a time
  assign in_stall_o  = state_q != ole_pkg::ST_IDLE;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign fire        = (state_q == ole_pkg::ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ole_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ole_pkg::ST_EXEC;
        end
      end
      ole_pkg::ST_EXEC: begin
        if (fire) begin
          state_d = ole_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ole_pkg::ST_IDLE;
      end
    endcase
  end

  // key at storage width
  if (DATA_WIDTH <= ole_pkg::WORD_W) begin : g_key_cut
    assign key = req_q.value[DATA_WIDTH-1:0];
  end else begin : g_key_ext
    assign key = {{(DATA_WIDTH - ole_pkg::WORD_W){req_q.value[ole_pkg::WORD_W-1]}},
                  req_q.value};
  end

  // read word back to 32 bits
  if (DATA_WIDTH >= ole_pkg::WORD_W) begin : g_rd_cut
    assign rd_ext = rd_or[ole_pkg::WORD_W-1:0];
  end else begin : g_rd_ext
    assign rd_ext = {{(ole_pkg::WORD_W - DATA_WIDTH){rd_or[DATA_WIDTH-1]}}, rd_or};
  end

  assign cnt_x   = CMP_W'(cnt_q);
  assign pos_x   = CMP_W'(req_q.position);
  assign idx_pos = IDX_W'(pos_x - CMP_W'(1));
  assign full    = cnt_q == CNT_W'(CAPACITY);
  assign empty   = cnt_q == '0;
  assign found   = seen_w[CAPACITY];

  // request evaluation against the current list
  always_comb begin
    status    = ole_pkg::STAT_OK;
    cmd       = '0;
    idx       = idx_pos;
    cnt_nx    = cnt_q;
    want_fpos = 1'b0;
    want_rval = 1'b0;
    unique case (ole_pkg::req_e'(req_q.req_type))
      ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_INS_END: begin
        if (full) begin
          status = ole_pkg::STAT_FULL;
        end else begin
          cmd.ins = 1'b1;
          idx     = (ole_pkg::req_e'(req_q.req_type) == ole_pkg::REQ_INS_HEAD) ?
                    '0 : IDX_W'(cnt_q);
          cnt_nx  = cnt_q + CNT_W'(1);
        end
      end
      ole_pkg::REQ_INS_AT: begin
        if (full) begin
          status = ole_pkg::STAT_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          status = ole_pkg::STAT_BAD_POS;
        end else begin
          cmd.ins = 1'b1;
          cnt_nx  = cnt_q + CNT_W'(1);
        end
      end
      ole_pkg::REQ_DEL_HEAD, ole_pkg::REQ_DEL_END: begin
        if (empty) begin
          status = ole_pkg::STAT_EMPTY;
        end else begin
          // deleting the tail shifts only cells at or past it, which fall outside the new count
          cmd.del_pos = 1'b1;
          idx         = (ole_pkg::req_e'(req_q.req_type) == ole_pkg::REQ_DEL_HEAD) ?
                        '0 : IDX_W'(cnt_q - CNT_W'(1));
          cnt_nx      = cnt_q - CNT_W'(1);
        end
      end
      ole_pkg::REQ_DEL_VAL, ole_pkg::REQ_FIND: begin
        if (empty) begin
          status = ole_pkg::STAT_EMPTY;
        end else if (!found) begin
          status = ole_pkg::STAT_NOT_FOUND;
        end else if (ole_pkg::req_e'(req_q.req_type) == ole_pkg::REQ_DEL_VAL) begin
          cmd.del_match = 1'b1;
          cnt_nx        = cnt_q - CNT_W'(1);
        end else begin
          want_fpos = 1'b1;
        end
      end
      ole_pkg::REQ_CLEAR: begin
        cnt_nx = '0;
      end
      ole_pkg::REQ_READ, ole_pkg::REQ_WRITE: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          status = ole_pkg::STAT_BAD_POS;
        end else if (ole_pkg::req_e'(req_q.req_type) == ole_pkg::REQ_READ) begin
          want_rval = 1'b1;
        end else begin
          cmd.wr = 1'b1;
        end
      end
      default: begin
        // unused request codes leave everything as it is
        status = ole_pkg::STAT_OK;
      end
    endcase
  end

  assign cell_cmd = fire ? cmd : '0;
  assign cnt_nx_x = CMP_W'(cnt_nx);
  assign fpos_x   = want_fpos ? CMP_W'(fpos_enc) : '0;

  always_comb begin
    res.status         = status;
    res.found_position = fpos_x[ole_pkg::POS_W-1:0];
    res.read_value     = want_rval ? rd_ext : '0;
    res.count          = cnt_nx_x[ole_pkg::POS_W-1:0];
    res.is_empty       = cnt_nx == '0;
  end

  // first match position, one-based, and the selected word for reads
  always_comb begin
    fpos_enc = '0;
    rd_or    = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first_w[i]) begin
        fpos_enc = fpos_enc | CNT_W'(i + 1);
      end
      rd_or = rd_or | rd_w[i];
    end
  end

  assign seen_w[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (g == 0) begin : g_head
      assign left_data = data_w[g];
    end else begin : g_mid_l
      assign left_data = data_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_data = data_w[g];
    end else begin : g_mid_r
      assign right_data = data_w[g+1];
    end

    ole_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .IDX        (g)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cell_cmd),
      .idx_i        (idx),
      .count_i      (cnt_q),
      .key_i        (key),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .seen_i       (seen_w[g]),
      .seen_o       (seen_w[g+1]),
      .first_o      (first_w[g]),
      .data_o       (data_w[g]),
      .rd_o         (rd_w[g])
    );
  end

  assign cnt_d       = fire ? cnt_nx : cnt_q;
  assign out_valid_d = fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ole_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_item_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

endmodule

>>> design/ole_checker.sv
// port-level checks for the ordered list engine, bound to the top level
module ole_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ole_pkg::out_item_t out_item_o
);

  // a stalled result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // one request in flight: the block stalls right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  // empty flag follows the reported count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.is_empty == (out_item_o.count == '0))
    else $error("empty flag disagrees with count");

  // a failed request reports no position and no data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ole_pkg::STAT_OK |->
      out_item_o.found_position == '0 && out_item_o.read_value == '0)
    else $error("failed request carries position or data");

  // a result never comes before the request cycle has passed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a request in flight");

endmodule

bind ordered_list_engine_unit ole_checker u_ole_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

>>> tb/testbench.sv
// self-checking testbench for the ordered list engine
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned REQ_W  = ole_pkg::REQ_W;
  localparam int unsigned WORD_W = ole_pkg::WORD_W;
  localparam int unsigned POS_W  = ole_pkg::POS_W;

  localparam int unsigned LIST_CAP     = 64;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 60;

  // request codes the block decodes as no-ops
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd10;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               out_stall_i = 1'b0;
  ole_pkg::in_item_t  in_item_i   = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  ole_pkg::out_item_t out_item_o;

  // list mirror, updated at each accepted request beat
  logic [WORD_W-1:0]  list_store [LIST_CAP];
  int unsigned        list_len = 0;
  ole_pkg::out_item_t pending_results_q [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned hold_asks   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;

  ordered_list_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // open a slot at idx by shifting the tail right
  function automatic void list_insert(input int unsigned idx, input logic [WORD_W-1:0] val);
    for (int unsigned i = list_len; i > idx; i--) list_store[i] = list_store[i-1];
    list_store[idx] = val;
    list_len++;
  endfunction

  // close the slot at idx by shifting the tail left
  function automatic void list_remove(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
    list_len--;
  endfunction

  // applies one request to the mirror and returns the result beat it must give
  function automatic ole_pkg::out_item_t list_apply(input ole_pkg::in_item_t rq);
    ole_pkg::out_item_t res;
    int                 hit;
    int unsigned        pos;
    res = '0;
    hit = -1;
    pos = 32'(rq.position);
    case (rq.req_type)
      ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_INS_END: begin
        if (list_len >= LIST_CAP) res.status = ole_pkg::STAT_FULL;
        else list_insert((rq.req_type == ole_pkg::REQ_INS_HEAD) ? 0 : list_len, rq.value);
      end
      ole_pkg::REQ_INS_AT: begin
        // full wins over a bad position
        if (list_len >= LIST_CAP) res.status = ole_pkg::STAT_FULL;
        else if (pos < 1 || pos > list_len + 1) res.status = ole_pkg::STAT_BAD_POS;
        else list_insert(pos - 1, rq.value);
      end
      ole_pkg::REQ_DEL_HEAD, ole_pkg::REQ_DEL_END: begin
        if (list_len == 0) res.status = ole_pkg::STAT_EMPTY;
        else list_remove((rq.req_type == ole_pkg::REQ_DEL_HEAD) ? 0 : list_len - 1);
      end
      ole_pkg::REQ_DEL_VAL, ole_pkg::REQ_FIND: begin
        if (list_len == 0) begin
          res.status = ole_pkg::STAT_EMPTY;
        end else begin
          for (int i = 0; i < int'(list_len); i++) begin
            if (hit < 0 && list_store[i] == rq.value) hit = i;
          end
          if (hit < 0) res.status = ole_pkg::STAT_NOT_FOUND;
          else if (rq.req_type == ole_pkg::REQ_DEL_VAL) list_remove(unsigned'(hit));
          else res.found_position = POS_W'(hit + 1);
        end
      end
      ole_pkg::REQ_CLEAR: list_len = 0;
      ole_pkg::REQ_READ, ole_pkg::REQ_WRITE: begin
        if (pos < 1 || pos > list_len) res.status = ole_pkg::STAT_BAD_POS;
        else if (rq.req_type == ole_pkg::REQ_READ) res.read_value = list_store[pos-1];
        else list_store[pos-1] = rq.value;
      end
      default: ; // unused codes leave everything alone
    endcase
    res.count    = POS_W'(list_len);
    res.is_empty = (list_len == 0);
    return res;
  endfunction

  task automatic report_field(input string name, input logic [WORD_W-1:0] exp_val,
                              input logic [WORD_W-1:0] act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      // keep the log short when the block is badly broken
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, exp_val, act_val);
    end
  endtask

  // result check first, then prediction of the beat taken at the same edge
  always @(posedge clk_i) begin
    ole_pkg::out_item_t want;
    ole_pkg::out_item_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_item_o;
        if (pending_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result beat with nothing pending, expected none got %0h",
                     $realtime, got);
        end else begin
          want = pending_results_q.pop_front();
          report_field("status", WORD_W'(want.status), WORD_W'(got.status));
          report_field("found_position", WORD_W'(want.found_position),
                       WORD_W'(got.found_position));
          report_field("read_value", want.read_value, got.read_value);
          report_field("count", WORD_W'(want.count), WORD_W'(got.count));
          report_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
        end
      end
      if (in_valid_i && !in_stall_o) pending_results_q.push_back(list_apply(in_item_i));
    end
  end

  // receiver: random stall patterns, each held for a random stretch, plus a long
  // hold-off whenever the stimulus asks for one
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still pending", $realtime,
               pending_results_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // offers one request beat and returns once it is taken; valid stays up
  // within a burst, and drops only for the gap between bursts
  task automatic send_req(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int unsigned gap;
    in_item_i  <= '{req_type: code, value: val, position: pos};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // corner cases on an empty list, the word extremes and the unused codes
  task automatic test_directed();
    send_req(ole_pkg::REQ_READ, 32'd0, 7'd1);
    send_req(ole_pkg::REQ_DEL_HEAD, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_DEL_END, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_DEL_VAL, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_FIND, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_WRITE, 32'd5, 7'd1);
    send_req(ole_pkg::REQ_INS_AT, 32'd9, 7'd0);
    send_req(ole_pkg::REQ_INS_AT, 32'd9, 7'd2);
    send_req(ole_pkg::REQ_INS_HEAD, WORD_MAX, 7'd0);
    send_req(ole_pkg::REQ_INS_END, WORD_MIN, 7'd0);
    send_req(ole_pkg::REQ_INS_AT, 32'd0, 7'd2);
    send_req(ole_pkg::REQ_INS_AT, 32'hffff_ffff, 7'd4);  // append through insert at
    send_req(ole_pkg::REQ_FIND, WORD_MIN, 7'd0);
    send_req(ole_pkg::REQ_READ, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_READ, 32'd0, 7'd5);
    send_req(ole_pkg::REQ_READ, 32'd0, 7'd3);
    send_req(ole_pkg::REQ_WRITE, 32'd1, 7'd1);
    send_req(ole_pkg::REQ_FIND, 32'd12345, 7'd0);
    send_req(ole_pkg::REQ_DEL_VAL, 32'd12345, 7'd0);
    send_req(ole_pkg::REQ_DEL_VAL, 32'd0, 7'd0);
    send_req(REQ_UNUSED_HI, 32'hffff_ffff, 7'd127);
    send_req(REQ_UNUSED_LO, 32'd0, 7'd64);
    send_req(ole_pkg::REQ_DEL_HEAD, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_DEL_END, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_CLEAR, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_CLEAR, 32'd0, 7'd0);
  endtask

  // fills the list to capacity and hits the full and last-position cases
  task automatic test_fill_and_full();
    int unsigned kind;
    send_req(ole_pkg::REQ_CLEAR, 32'd0, 7'd0);
    for (int unsigned n = 0; n < LIST_CAP; n++) begin
      kind = $urandom_range(0, 2);
      if (kind == 0) send_req(ole_pkg::REQ_INS_HEAD, $urandom, 7'd0);
      else if (kind == 1) send_req(ole_pkg::REQ_INS_END, $urandom, 7'd0);
      else send_req(ole_pkg::REQ_INS_AT, $urandom, POS_W'($urandom_range(1, n + 1)));
    end
    send_req(ole_pkg::REQ_INS_HEAD, 32'd1, 7'd0);
    send_req(ole_pkg::REQ_INS_END, 32'd2, 7'd0);
    send_req(ole_pkg::REQ_INS_AT, 32'd3, 7'd0);
    send_req(ole_pkg::REQ_INS_AT, 32'd4, 7'd65);
    send_req(ole_pkg::REQ_INS_AT, 32'd5, 7'd127);
    send_req(ole_pkg::REQ_WRITE, WORD_MIN, 7'd64);
    send_req(ole_pkg::REQ_READ, 32'd0, 7'd64);
    send_req(ole_pkg::REQ_READ, 32'd0, 7'd65);
    send_req(ole_pkg::REQ_FIND, WORD_MIN, 7'd0);
    send_req(ole_pkg::REQ_WRITE, 32'd7, 7'd65);
    send_req(ole_pkg::REQ_DEL_END, 32'd0, 7'd0);
    send_req(ole_pkg::REQ_INS_AT, WORD_MAX, 7'd65);  // two past the end while one short of full
    send_req(ole_pkg::REQ_INS_AT, WORD_MAX, 7'd64);
    send_req(ole_pkg::REQ_DEL_VAL, WORD_MAX, 7'd0);
    send_req(ole_pkg::REQ_CLEAR, 32'd0, 7'd0);
  endtask

  // mostly well-formed requests with random content; the list swings
  // between empty and full so every status shows up many times
  task automatic test_random_mix(input int unsigned n_items);
    logic [WORD_W-1:0] pool [8];
    logic [REQ_W-1:0]  code;
    logic [WORD_W-1:0] val;
    logic [POS_W-1:0]  pos;
    bit                growing;
    int unsigned       len;
    int unsigned       pick;
    pool    = '{32'd0, 32'd1, 32'hffff_ffff, WORD_MAX, WORD_MIN, 32'd5, 32'd42, 32'hffff_fff9};
    growing = 1'b1;
    for (int unsigned n = 0; n < n_items; n++) begin
      len = list_len;
      if (len >= LIST_CAP) growing = 1'b0;
      else if (len == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) == 0) growing = ~growing;

      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        code = growing ?
               REQ_W'($urandom_range(ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_INS_AT)) :
               REQ_W'($urandom_range(ole_pkg::REQ_DEL_HEAD, ole_pkg::REQ_DEL_VAL));
      end else if (pick < 45) begin
        code = growing ?
               REQ_W'($urandom_range(ole_pkg::REQ_DEL_HEAD, ole_pkg::REQ_DEL_VAL)) :
               REQ_W'($urandom_range(ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_INS_AT));
      end else if (pick < 96) begin
        code = REQ_W'($urandom_range(ole_pkg::REQ_FIND, ole_pkg::REQ_WRITE));
      end else if (pick < 97) begin
        code = ole_pkg::REQ_CLEAR;
      end else begin
        code = REQ_W'($urandom_range(0, 15));  // noise, unused codes included
      end

      pick = $urandom_range(0, 9);
      if (pick < 4 && len > 0) val = list_store[$urandom_range(0, len - 1)];
      else if (pick < 7) val = pool[$urandom_range(0, 7)];
      else val = $urandom;

      if ($urandom_range(0, 6) == 0) pos = POS_W'($urandom_range(0, 127));
      else if (code == ole_pkg::REQ_INS_AT) pos = POS_W'($urandom_range(1, len + 1));
      else pos = POS_W'($urandom_range(1, (len > 0) ? len : 1));

      send_req(code, val, pos);
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming, so the
  // block fills up and stalls its input
  task automatic test_backpressure();
    hold_asks <= hold_asks + 1;
    for (int unsigned n = 0; n < 40; n++) begin
      if (n % 4 == 3) send_req(ole_pkg::REQ_FIND, $urandom, 7'd0);
      else send_req(ole_pkg::REQ_INS_AT, $urandom, POS_W'($urandom_range(0, 66)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_and_full();
    test_backpressure();
    test_random_mix(1800);

    in_valid_i <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    // any stray result beat in this window is flagged by the result check above
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
